FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL that checks its own logic.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("camera row packetizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("camera row packetizer: next-cycle check failed");

`endif

FILE: rtl/core/crp_pkg.sv
`default_nettype none

package crp_pkg;

    localparam int ROW_W   = 12;
    localparam int OFF_W   = 13;
    localparam int LEN_W   = 14;
    localparam int SLOT_W  = 6;
    localparam int FRAME_W = 8;

    // Item modes.
    localparam logic [1:0] MODE_POLL  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // Capture interface requests.
    localparam logic [1:0] CAP_NONE    = 2'd0;
    localparam logic [1:0] CAP_ENABLE  = 2'd1;
    localparam logic [1:0] CAP_DISABLE = 2'd2;
    localparam logic [1:0] CAP_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic             link_ready;
        logic             endpoint_busy;
        logic [ROW_W-1:0] rows_captured;
        logic             capture_done;
        logic             capture_running;
    } t_item;

    typedef struct packed {
        logic               streaming;
        logic [ROW_W-1:0]   row;
        logic [OFF_W-1:0]   offset;
        logic [FRAME_W-1:0] frame_id;
        logic [SLOT_W-1:0]  slot;
    } t_state;

    typedef struct packed {
        logic               packet_valid;
        logic [FRAME_W-1:0] frame_number;
        logic [ROW_W-1:0]   row_number;
        logic [OFF_W-1:0]   row_offset;
        logic [LEN_W-1:0]   payload_length;
        logic [SLOT_W-1:0]  buffer_slot;
        logic [1:0]         capture_action;
        logic               clear_capture_done;
        logic               frame_complete;
        logic               is_streaming;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/camera_row_packetizer.sv
// Channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// input    | i_valid / o_stall   | i_mode, i_link_ready, i_endpoint_busy, ...
// result   | o_valid / i_stall   | o_packet_valid, o_frame_number, ... o_is_streaming
//
// One item is accepted per cycle while o_stall is low, and each gives exactly one result item.
// Each item passes the input register, then the result register.
// Reset is synchronous and active low; it clears the session state and the
// valid flags. A two-entry result buffer absorbs a stall, so o_stall rises only
// when both result entries and the input register are occupied.
`default_nettype none

module camera_row_packetizer #(
    parameter int LINE_LENGTH   = 1280,
    parameter int PAYLOAD_LIMIT = 1015,
    parameter int FRAME_ROWS    = 480,
    parameter int LINE_BUFFERS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_link_ready,
    input  logic        i_endpoint_busy,
    input  logic [11:0] i_rows_captured,
    input  logic        i_capture_done,
    input  logic        i_capture_running,
    // Result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_packet_valid,
    output logic [7:0]  o_frame_number,
    output logic [11:0] o_row_number,
    output logic [12:0] o_row_offset,
    output logic [13:0] o_payload_length,
    output logic [5:0]  o_buffer_slot,
    output logic [1:0]  o_capture_action,
    output logic        o_clear_capture_done,
    output logic        o_frame_complete,
    output logic        o_is_streaming
);
    import crp_pkg::*;

    // Input register holding the item that is processed next.
    logic    r_a_valid;
    t_item   r_a_item;
    // Session state: streaming flag, row, offset, frame id and the buffer slot
    // of the current row, which is kept alongside so that no modulo is needed.
    t_state  r_state;

    t_state  n_state;
    t_result step_res;
    t_result out_res;
    logic    buf_full;
    logic    accept;
    logic    advance;

    assign advance = r_a_valid && !buf_full;
    assign o_stall = r_a_valid && buf_full;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_state   <= '0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_a_item  <= '{mode:            i_mode,
                               link_ready:      i_link_ready,
                               endpoint_busy:   i_endpoint_busy,
                               rows_captured:   i_rows_captured,
                               capture_done:    i_capture_done,
                               capture_running: i_capture_running};
            end else if (advance) begin
                r_a_valid <= 1'b0;
            end
            // The state moves on exactly when its item enters the result buffer.
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    crp_step #(
        .LINE_LENGTH   (LINE_LENGTH),
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT),
        .FRAME_ROWS    (FRAME_ROWS),
        .LINE_BUFFERS  (LINE_BUFFERS)
    ) u_step (
        .i_item   (r_a_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_res)
    );

    crp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (step_res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_res),
        .i_stall (i_stall)
    );

    assign o_packet_valid       = out_res.packet_valid;
    assign o_frame_number       = out_res.frame_number;
    assign o_row_number         = out_res.row_number;
    assign o_row_offset         = out_res.row_offset;
    assign o_payload_length     = out_res.payload_length;
    assign o_buffer_slot        = out_res.buffer_slot;
    assign o_capture_action     = out_res.capture_action;
    assign o_clear_capture_done = out_res.clear_capture_done;
    assign o_frame_complete     = out_res.frame_complete;
    assign o_is_streaming       = out_res.is_streaming;

`include "assert_macros.svh"

    // The offset always stays inside the row, below the line length.
    `CRP_ASSERT_IMP(a_offset_in_row, 1'b1, {1'b0, r_state.offset} < LEN_W'(LINE_LENGTH))
    // A packet never asks to disable or restart the capture.
    `CRP_ASSERT_IMP(a_packet_action, o_valid && o_packet_valid,
                    o_capture_action == CAP_NONE || o_capture_action == CAP_ENABLE)
    // A completed frame always opens a new streaming session.
    `CRP_ASSERT_IMP(a_frame_restart, o_valid && o_frame_complete,
                    o_is_streaming && o_capture_action == CAP_RESTART && !o_packet_valid)
    // A held input item keeps the session state frozen.
    `CRP_ASSERT_NXT(a_state_hold, o_stall, $stable(r_state))

endmodule

`default_nettype wire

FILE: rtl/core/crp_step.sv
`default_nettype none

module crp_step #(
    parameter int LINE_LENGTH   = 1280,
    parameter int PAYLOAD_LIMIT = 1015,
    parameter int FRAME_ROWS    = 480,
    parameter int LINE_BUFFERS  = 8
) (
    input  crp_pkg::t_item   i_item,
    input  crp_pkg::t_state  i_state,
    output crp_pkg::t_state  o_state,
    output crp_pkg::t_result o_result
);
    import crp_pkg::*;

    localparam logic [LEN_W-1:0]  LL_W    = LEN_W'(LINE_LENGTH);
    localparam logic [LEN_W-1:0]  PL_W    = LEN_W'(PAYLOAD_LIMIT);
    localparam logic [ROW_W-1:0]  FR_W    = ROW_W'(FRAME_ROWS);
    localparam logic [ROW_W:0]    LB_W    = (ROW_W + 1)'(LINE_BUFFERS);
    localparam logic [SLOT_W-1:0] LB_LAST = SLOT_W'(LINE_BUFFERS - 1);

    logic [LEN_W-1:0]  off_w;
    logic [LEN_W-1:0]  remain;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  sum;
    logic              end_of_row;
    logic [ROW_W-1:0]  row_inc;
    logic [SLOT_W-1:0] slot_inc;
    logic [ROW_W-1:0]  row_after;
    logic [ROW_W-1:0]  rows_left;
    logic              room;
    t_state            ns;
    t_result           res;

    // Packet length and the position that follows the packet.
    always_comb begin
        off_w      = {1'b0, i_state.offset};
        remain     = (off_w < LL_W) ? (LL_W - off_w) : '0;
        len        = (remain > PL_W) ? PL_W : remain;
        sum        = off_w + len;
        end_of_row = (sum >= LL_W);
        row_inc    = i_state.row + ROW_W'(1);
        // The slot follows the row modulo the buffer count, also when the row wraps.
        if (i_state.row == {ROW_W{1'b1}}) begin
            slot_inc = '0;
        end else if (i_state.slot == LB_LAST) begin
            slot_inc = '0;
        end else begin
            slot_inc = i_state.slot + SLOT_W'(1);
        end
        row_after  = end_of_row ? row_inc : i_state.row;
        rows_left  = i_item.rows_captured - row_after;
        room       = (i_item.rows_captured >= row_after) && ({1'b0, rows_left} < LB_W);
    end

    always_comb begin
        ns  = i_state;
        res = '0;
        if (i_item.link_ready) begin
            case (i_item.mode)
                MODE_START: begin
                    ns.streaming           = 1'b1;
                    ns.row                 = '0;
                    ns.offset              = '0;
                    ns.slot                = '0;
                    ns.frame_id            = i_state.frame_id + FRAME_W'(1);
                    res.capture_action     = CAP_RESTART;
                    res.clear_capture_done = 1'b1;
                end
                MODE_STOP: begin
                    ns.streaming           = 1'b0;
                    ns.row                 = '0;
                    ns.offset              = '0;
                    ns.slot                = '0;
                    res.capture_action     = CAP_DISABLE;
                    res.clear_capture_done = 1'b1;
                end
                MODE_POLL: begin
                    if (i_state.streaming && !i_item.endpoint_busy) begin
                        if (i_state.row < i_item.rows_captured) begin
                            res.packet_valid   = 1'b1;
                            res.row_number     = i_state.row;
                            res.row_offset     = i_state.offset;
                            res.payload_length = len;
                            res.buffer_slot    = i_state.slot;
                            if (end_of_row) begin
                                ns.offset = '0;
                                ns.row    = row_inc;
                                ns.slot   = slot_inc;
                            end else begin
                                ns.offset = sum[OFF_W-1:0];
                            end
                            if (!i_item.capture_done && room && !i_item.capture_running
                                && (i_item.rows_captured < FR_W)) begin
                                res.capture_action = CAP_ENABLE;
                            end
                        end else if (i_item.capture_done && (i_state.row >= FR_W)
                                     && (i_state.offset == '0)) begin
                            ns.streaming           = 1'b1;
                            ns.row                 = '0;
                            ns.offset              = '0;
                            ns.slot                = '0;
                            ns.frame_id            = i_state.frame_id + FRAME_W'(1);
                            res.capture_action     = CAP_RESTART;
                            res.clear_capture_done = 1'b1;
                            res.frame_complete     = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        res.frame_number = ns.frame_id;
        res.is_streaming = ns.streaming;
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

`default_nettype wire

FILE: rtl/core/crp_out_buf.sv
`default_nettype none

module crp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crp_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output crp_pkg::t_result o_data,
    input  logic             i_stall
);
    import crp_pkg::*;

    logic    r_m_valid;
    logic    r_s_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    // A push is only offered while the skid entry is free.
    assign pop = r_m_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (i_push && pop) begin
                r_main <= i_data;
            end else if (pop) begin
                if (r_s_valid) begin
                    r_main    <= r_skid;
                    r_s_valid <= 1'b0;
                end else begin
                    r_m_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_m_valid) begin
                    r_main    <= i_data;
                    r_m_valid <= 1'b1;
                end else begin
                    r_skid    <= i_data;
                    r_s_valid <= 1'b1;
                end
            end
        end
    end

    assign o_full  = r_s_valid;
    assign o_valid = r_m_valid;
    assign o_data  = r_main;

endmodule

`default_nettype wire

FILE: bench/camera_row_packetizer_tb.sv
`timescale 1ns / 100ps

module camera_row_packetizer_tb;

    import crp_pkg::*;

    // The packetizer is checked at its default geometry.
    localparam int LINE_LENGTH   = 1280;
    localparam int PAYLOAD_LIMIT = 1015;
    localparam int FRAME_ROWS    = 480;
    localparam int LINE_BUFFERS  = 8;

    // The fourth mode code has no meaning and must be ignored by the block.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode            = MODE_POLL;
    logic        i_link_ready      = 1'b0;
    logic        i_endpoint_busy   = 1'b0;
    logic [11:0] i_rows_captured   = '0;
    logic        i_capture_done    = 1'b0;
    logic        i_capture_running = 1'b0;
    logic        o_valid;
    logic        i_stall           = 1'b0;
    logic        o_packet_valid;
    logic [7:0]  o_frame_number;
    logic [11:0] o_row_number;
    logic [12:0] o_row_offset;
    logic [13:0] o_payload_length;
    logic [5:0]  o_buffer_slot;
    logic [1:0]  o_capture_action;
    logic        o_clear_capture_done;
    logic        o_frame_complete;
    logic        o_is_streaming;

    camera_row_packetizer #(
        .LINE_LENGTH  (LINE_LENGTH),
        .PAYLOAD_LIMIT(PAYLOAD_LIMIT),
        .FRAME_ROWS   (FRAME_ROWS),
        .LINE_BUFFERS (LINE_BUFFERS)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_link_ready        (i_link_ready),
        .i_endpoint_busy     (i_endpoint_busy),
        .i_rows_captured     (i_rows_captured),
        .i_capture_done      (i_capture_done),
        .i_capture_running   (i_capture_running),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_packet_valid      (o_packet_valid),
        .o_frame_number      (o_frame_number),
        .o_row_number        (o_row_number),
        .o_row_offset        (o_row_offset),
        .o_payload_length    (o_payload_length),
        .o_buffer_slot       (o_buffer_slot),
        .o_capture_action    (o_capture_action),
        .o_clear_capture_done(o_clear_capture_done),
        .o_frame_complete    (o_frame_complete),
        .o_is_streaming      (o_is_streaming)
    );

    always #10 i_clk = ~i_clk;

    // Items waiting to be sent, and the packet headers they are expected to produce.
    t_item   pending_items[$];
    t_result expected_packets[$];
    t_result last_prediction;
    int      error_count = 0;

    // Session state as the packetizer should hold it.
    logic               sess_streaming = 1'b0;
    logic [ROW_W-1:0]   sess_row       = '0;
    logic [OFF_W-1:0]   sess_offset    = '0;
    logic [FRAME_W-1:0] sess_frame     = '0;

    // Opening a session restarts the capture and moves on to the next frame id.
    function automatic void open_session(inout t_result res);
        sess_streaming = 1'b1;
        sess_row = '0;
        sess_offset = '0;
        sess_frame = sess_frame + FRAME_W'(1);
        res.capture_action = CAP_RESTART;
        res.clear_capture_done = 1'b1;
    endfunction

    // Works out the single result of one item and advances the session state.
    function automatic t_result packetize_item(input t_item it);
        t_result     res;
        int unsigned remain;
        int unsigned len;
        int unsigned next_offset;
        int unsigned rows;
        res = '0;
        rows = it.rows_captured;
        if (it.link_ready) begin
            if (it.mode == MODE_START) begin
                open_session(res);
            end else if (it.mode == MODE_STOP) begin
                sess_streaming = 1'b0;
                sess_row = '0;
                sess_offset = '0;
                res.capture_action = CAP_DISABLE;
                res.clear_capture_done = 1'b1;
            end else if (it.mode == MODE_POLL && sess_streaming && !it.endpoint_busy) begin
                if (sess_row < rows) begin
                    remain = (sess_offset < LINE_LENGTH) ? LINE_LENGTH - sess_offset : 0;
                    len = (remain > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : remain;
                    res.packet_valid = 1'b1;
                    res.frame_number = sess_frame;
                    res.row_number = sess_row;
                    res.row_offset = sess_offset;
                    res.payload_length = LEN_W'(len);
                    res.buffer_slot = SLOT_W'(sess_row % LINE_BUFFERS);
                    next_offset = sess_offset + len;
                    if (next_offset >= LINE_LENGTH) begin
                        next_offset = 0;
                        sess_row = sess_row + ROW_W'(1);
                    end
                    sess_offset = OFF_W'(next_offset);
                    // Capture resumes once the ring of line buffers has room again.
                    if (!it.capture_done && rows >= sess_row
                            && (rows - sess_row) < LINE_BUFFERS
                            && !it.capture_running && rows < FRAME_ROWS) begin
                        res.capture_action = CAP_ENABLE;
                    end
                end else if (it.capture_done && sess_row >= FRAME_ROWS && sess_offset == 0) begin
                    open_session(res);
                    res.frame_complete = 1'b1;
                end
            end
        end
        if (!res.packet_valid) begin
            res.frame_number = sess_frame;
        end
        res.is_streaming = sess_streaming;
        return res;
    endfunction

    task automatic enqueue_item(input logic [1:0] mode, input bit link, input bit busy,
                                input int unsigned rows, input bit done, input bit running);
        t_item it;
        it.mode = mode;
        it.link_ready = link;
        it.endpoint_busy = busy;
        it.rows_captured = ROW_W'(rows);
        it.capture_done = done;
        it.capture_running = running;
        pending_items.push_back(it);
        last_prediction = packetize_item(it);
        expected_packets.push_back(last_prediction);
    endtask

    // Sender: bursts of random length separated by random gaps. A new item is
    // only put up once the one on the port has been taken.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                pending_items.delete(0);
            end
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                i_valid <= 1'b0;
            end else begin
                i_mode            <= pending_items[0].mode;
                i_link_ready      <= pending_items[0].link_ready;
                i_endpoint_busy   <= pending_items[0].endpoint_busy;
                i_rows_captured   <= pending_items[0].rows_captured;
                i_capture_done    <= pending_items[0].capture_done;
                i_capture_running <= pending_items[0].capture_running;
                i_valid           <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                end
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Receiver: the stall pattern rotates between none,
    // random stalls and a fixed three-in-seven rhythm.
    int unsigned rcv_cycle = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_packets.size() == 0) begin
                    $display("%0t: result item with none expected, frame %0d row %0d",
                             $time, o_frame_number, o_row_number);
                    error_count++;
                end else begin
                    want = expected_packets.pop_front();
                    check_field("packet_valid", want.packet_valid, o_packet_valid);
                    check_field("frame_number", want.frame_number, o_frame_number);
                    check_field("row_number", want.row_number, o_row_number);
                    check_field("row_offset", want.row_offset, o_row_offset);
                    check_field("payload_length", want.payload_length, o_payload_length);
                    check_field("buffer_slot", want.buffer_slot, o_buffer_slot);
                    check_field("capture_action", want.capture_action, o_capture_action);
                    check_field("clear_capture_done", want.clear_capture_done,
                                o_clear_capture_done);
                    check_field("frame_complete", want.frame_complete, o_frame_complete);
                    check_field("is_streaming", want.is_streaming, o_is_streaming);
                end
            end
            case ((rcv_cycle >> 8) % 3)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ((rcv_cycle % 7) < 3);
            endcase
            rcv_cycle++;
        end
    end

    initial begin
        int unsigned rows;
        int unsigned pick;
        int          frame_items;
        logic [1:0]  mode;
        bit          done;

        // Directed opening: commands while idle and with the link down, the
        // ignored mode, a busy endpoint, nothing pending, both packets of a
        // row, capture re-enable and the largest row count.
        enqueue_item(MODE_POLL,   1, 0, 4095, 1, 1);
        enqueue_item(MODE_START,  0, 0, 0,    0, 0);
        enqueue_item(MODE_UNUSED, 1, 0, 0,    0, 0);
        enqueue_item(MODE_STOP,   1, 0, 0,    0, 0);
        enqueue_item(MODE_START,  1, 0, 0,    0, 0);
        enqueue_item(MODE_POLL,   1, 1, 4095, 0, 0);
        enqueue_item(MODE_POLL,   1, 0, 0,    0, 0);
        enqueue_item(MODE_POLL,   1, 0, 0,    1, 0);
        enqueue_item(MODE_POLL,   1, 0, 5,    0, 0);
        enqueue_item(MODE_POLL,   1, 0, 5,    0, 1);
        enqueue_item(MODE_POLL,   1, 0, 1,    0, 0);
        enqueue_item(MODE_POLL,   1, 0, 4095, 1, 0);
        enqueue_item(MODE_POLL,   0, 0, 4095, 0, 0);
        enqueue_item(MODE_POLL,   1, 0, 4095, 0, 0);
        enqueue_item(MODE_STOP,   1, 0, 0,    0, 0);
        enqueue_item(MODE_POLL,   1, 0, 4095, 0, 0);
        enqueue_item(MODE_START,  1, 0, 0,    0, 0);
        enqueue_item(MODE_UNUSED, 1, 1, 4095, 1, 1);
        enqueue_item(MODE_START,  1, 0, 0,    0, 0);

        // A whole frame streamed as a camera would: the captured row count runs
        // a little ahead of the packetizer, with some noise on top, until the
        // frame is finished and the next one opens on its own.
        enqueue_item(MODE_START, 1, 0, 0, 0, 0);
        frame_items = 0;
        do begin
            rows = sess_row + $urandom_range(0, 9);
            if (rows > FRAME_ROWS) begin
                rows = FRAME_ROWS;
            end
            if ($urandom_range(0, 31) == 0) begin
                rows = $urandom_range(0, 4095);
            end
            done = (rows >= FRAME_ROWS) ? ($urandom_range(0, 7) != 0)
                                        : ($urandom_range(0, 15) == 0);
            mode = ($urandom_range(0, 63) == 0) ? MODE_UNUSED : MODE_POLL;
            enqueue_item(mode, $urandom_range(0, 31) != 0, $urandom_range(0, 15) == 0,
                         rows, done, $urandom_range(0, 1));
            frame_items++;
        end while (!last_prediction.frame_complete && frame_items < 4000);

        // Loose mixture, mostly start commands so that the frame id wraps.
        repeat (300) begin
            pick = $urandom_range(0, 99);
            if (pick < 92) begin
                mode = MODE_START;
            end else if (pick < 96) begin
                mode = MODE_STOP;
            end else if (pick < 98) begin
                mode = MODE_POLL;
            end else begin
                mode = MODE_UNUSED;
            end
            enqueue_item(mode, $urandom_range(0, 31) != 0, $urandom_range(0, 1),
                         $urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 1));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (expected_packets.size() != 0 || pending_items.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
